// ===== hw/rtl/iss_pkg.sv =====
// shared constants for the integer summary statistics block
// no dependencies; imported by the channel interfaces and the top level
package iss_pkg;

  localparam int VAL_W = 7;                 // width of one sample and of each result field
  localparam int SQR_W = 2 * VAL_W;         // width of a squared deviation
  localparam logic [VAL_W-1:0] VALUE_LIMIT = 7'd100;
  localparam logic [VAL_W-1:0] MIN_RESET   = 7'd100;

endpackage

// ===== hw/rtl/iss_if.sv =====
// valid/ready channel interfaces for samples in and summary words out
// depends on iss_pkg for field widths
interface iss_in_if import iss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample_value;
  logic             end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface iss_out_if import iss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] largest;
  logic [VAL_W-1:0] smallest;
  logic [VAL_W-1:0] largest_count;
  logic [VAL_W-1:0] smallest_count;
  logic [VAL_W-1:0] mean_value;
  logic [VAL_W-1:0] std_deviation;
  logic             overflowed;

  modport source (output valid, output largest, output smallest, output largest_count,
                  output smallest_count, output mean_value, output std_deviation,
                  output overflowed, input ready);
  modport sink   (input valid, input largest, input smallest, input largest_count,
                  input smallest_count, input mean_value, input std_deviation,
                  input overflowed, output ready);
endinterface

// ===== hw/rtl/iss_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// standalone; shared by the mean and variance steps of the top level
module iss_div #(
  parameter int DW = 21,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] acc_r, acc_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [VW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, acc_r[DW-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = VW'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_nxt = rem_sh[VW-1:0];
      end
      acc_nxt = {acc_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

// ===== hw/rtl/integer_summary_statistics.sv =====
// integer summary statistics: max, min, their counts, mean and standard deviation
// depends on iss_pkg, iss_if (channels) and iss_div (shared divider)
//
// usage:
//   in_chan carries one sample word per handshake: sample_value and end_of_set.
//   a sample above 100 is dropped whole, end mark included. samples beyond
//   STORE_DEPTH are not stored and set the overflowed flag of the summary.
//   samples load one per cycle into the value memory while in_chan.ready is high.
//   after a word with end_of_set, in_chan.ready drops while the summary is
//   computed: a sum/count division, a scan of the memory at one entry per
//   cycle, a second division for the variance, a bit-by-bit square root
//   and a hand-off of the results to the output register.
//   the summary word sits in an output register on out_chan; if the receiver
//   stalls, loading of the next set resumes, and the next summary waits until
//   the held word is taken.
//   reset (rst_n low, synchronous) empties the set and drops any pending word.
module integer_summary_statistics import iss_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  iss_in_if.sink        in_chan,
  iss_out_if.source     out_chan
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int SQ_W   = SQR_W + CNT_W;
  localparam int HC_W   = (CNT_W > VAL_W) ? CNT_W : VAL_W;

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_DIV_MEAN = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_DIV_VAR  = 3'd3;
  localparam logic [2:0] S_SQRT     = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [VAL_W-1:0] mem [STORE_DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [VAL_W-1:0] max_r, max_nxt;
  logic [VAL_W-1:0] min_r, min_nxt;
  logic             ovf_r, ovf_nxt;
  logic [VAL_W-1:0] mean_r, mean_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [HC_W-1:0]  nmax_r, nmax_nxt;
  logic [HC_W-1:0]  nmin_r, nmin_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [SQR_W-1:0] var_r, var_nxt;
  logic [VAL_W-1:0] root_r, root_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic             div_start_r, div_start_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;

  logic [VAL_W-1:0] out_max_r, out_min_r, out_nmax_r, out_nmin_r;
  logic [VAL_W-1:0] out_mean_r, out_dev_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             in_good;
  logic             full;
  logic [VAL_W-1:0] dev;
  logic [SQR_W-1:0] dev_sq;
  logic [VAL_W-1:0] cand;
  logic [SQR_W-1:0] cand_sq;

  logic [SQ_W-1:0]  div_dividend;
  logic             div_done;
  logic [SQ_W-1:0]  div_quot;

  assign in_chan.ready = (state_r == S_LOAD);
  assign in_acc  = in_chan.valid & in_chan.ready;
  assign in_good = (in_chan.sample_value <= VALUE_LIMIT);
  assign full    = (count_r == CNT_W'(STORE_DEPTH));
  assign wr_en   = in_acc & in_good & ~full;

  assign div_dividend = (state_r == S_DIV_MEAN) ? SQ_W'(sum_r) : sq_r;

  iss_div #(
    .DW (SQ_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // distance of the scanned sample from the mean, and its square; also the square-root candidate and its square
  always_comb begin
    if (rd_data_r >= mean_r) begin
      dev = rd_data_r - mean_r;
    end else begin
      dev = mean_r - rd_data_r;
    end
    dev_sq  = SQR_W'(dev) * SQR_W'(dev);
    cand    = root_r | (VAL_W'(1) << bit_r);
    cand_sq = SQR_W'(cand) * SQR_W'(cand);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    ovf_nxt       = ovf_r;
    mean_nxt      = mean_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    rd_addr       = iss_r[ADDR_W-1:0];
    nmax_nxt      = nmax_r;
    nmin_nxt      = nmin_r;
    sq_nxt        = sq_r;
    var_nxt       = var_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_load      = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc && in_good) begin
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(in_chan.sample_value);
            if (in_chan.sample_value > max_r) begin
              max_nxt = in_chan.sample_value;
            end
            if (in_chan.sample_value < min_r) begin
              min_nxt = in_chan.sample_value;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.end_of_set) begin
            state_nxt     = S_DIV_MEAN;
            div_start_nxt = 1'b1;
          end
        end
      end
      S_DIV_MEAN: begin
        if (div_done) begin
          mean_nxt  = div_quot[VAL_W-1:0];
          iss_nxt   = '0;
          nmax_nxt  = '0;
          nmin_nxt  = '0;
          sq_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads go out one per cycle, data returns from the registered read port
        if (iss_r != count_r) begin
          iss_nxt    = iss_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          sq_nxt = sq_r + SQ_W'(dev_sq);
          if (rd_data_r == max_r) begin
            nmax_nxt = nmax_r + HC_W'(1);
          end
          if (rd_data_r == min_r) begin
            nmin_nxt = nmin_r + HC_W'(1);
          end
        end
        if (iss_r == count_r && !rd_vld_r) begin
          state_nxt     = S_DIV_VAR;
          div_start_nxt = 1'b1;
        end
      end
      S_DIV_VAR: begin
        if (div_done) begin
          var_nxt   = div_quot[SQR_W-1:0];
          root_nxt  = '0;
          bit_nxt   = 3'(VAL_W - 1);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cand_sq <= var_r) begin
          root_nxt = cand;
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up, then start a new set
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          sum_nxt       = '0;
          max_nxt       = '0;
          min_nxt       = MIN_RESET;
          ovf_nxt       = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= MIN_RESET;
      ovf_r       <= 1'b0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      bit_r       <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      ovf_r       <= ovf_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      bit_r       <= bit_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
    nmax_r <= nmax_nxt;
    nmin_r <= nmin_nxt;
    sq_r   <= sq_nxt;
    var_r  <= var_nxt;
    root_r <= root_nxt;
    if (out_load) begin
      out_max_r  <= max_r;
      out_min_r  <= min_r;
      out_nmax_r <= nmax_r[VAL_W-1:0];
      out_nmin_r <= nmin_r[VAL_W-1:0];
      out_mean_r <= mean_r;
      out_dev_r  <= root_r;
      out_ovf_r  <= ovf_r;
    end
  end

  // value memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= in_chan.sample_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.largest        = out_max_r;
  assign out_chan.smallest       = out_min_r;
  assign out_chan.largest_count  = out_nmax_r;
  assign out_chan.smallest_count = out_nmin_r;
  assign out_chan.mean_value     = out_mean_r;
  assign out_chan.std_deviation  = out_dev_r;
  assign out_chan.overflowed     = out_ovf_r;

endmodule
